/* src/trapezoid_servo_motion_controller_macros.svh */
// assertion macros used by the checker file
// no dependencies; clock and reset are the names used at the top level
`ifndef TRAPEZOID_SERVO_MOTION_CONTROLLER_MACROS_SVH
`define TRAPEZOID_SERVO_MOTION_CONTROLLER_MACROS_SVH

// checked only outside reset
`define TSMC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define TSMC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* src/tsmc_pkg.sv */
// shared types, codes and constants of the servo motion controller
// no dependencies
package tsmc_pkg;

   localparam int unsigned DIV_W = 34;
   localparam int unsigned MAX_PROFILE_TICKS_DEF = 4095;

   localparam logic [13:0] PERIOD_RST = 14'd100;
   localparam logic [9:0]  MAX_POS_RST = 10'd50;
   localparam logic [7:0]  MIN_SPEED_RST = 8'd1;
   localparam logic [7:0]  MAX_SPEED_RST = 8'd40;
   localparam logic [9:0]  RANGE_RST = 10'd750;
   localparam logic [9:0]  DEAD_BAND_RST = 10'd90;
   localparam logic [11:0] IDLE_PULSE_RST = 12'd1500;
   localparam logic signed [10:0] POSITION_RST = 11'sd50;

   localparam logic [2:0] CSR_PERIOD    = 3'd0;
   localparam logic [2:0] CSR_MAX_POS   = 3'd1;
   localparam logic [2:0] CSR_MIN_SPEED = 3'd2;
   localparam logic [2:0] CSR_MAX_SPEED = 3'd3;
   localparam logic [2:0] CSR_RANGE     = 3'd4;
   localparam logic [2:0] CSR_DEAD_BAND = 3'd5;
   localparam logic [2:0] CSR_IDLE      = 3'd6;

   localparam logic [2:0] STAT_NONE  = 3'd0;
   localparam logic [2:0] STAT_DRIVE = 3'd1;
   localparam logic [2:0] STAT_CREEP = 3'd2;
   localparam logic [2:0] STAT_REACH = 3'd3;
   localparam logic [2:0] STAT_HOME  = 3'd4;

   typedef enum logic [1:0] {
      CMD_TICK = 2'd0,
      CMD_STEP = 2'd1,
      CMD_MOVE = 2'd2,
      CMD_HOME = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_TRAP = 2'd0,
      KIND_MIN  = 2'd1,
      KIND_MAX  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      DOP_PEAK   = 2'd0,
      DOP_SPEED  = 2'd1,
      DOP_OFFSET = 2'd2
   } dop_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_MV_MUL,
      ST_MV_CMP,
      ST_TK_MUL,
      ST_TK_ADD,
      ST_OFF_MUL,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

   // idle plus or minus offset, saturating at 0 and 4095
   function automatic logic [11:0] drive_pulse(input logic [11:0] idle,
                                               input logic [9:0] offset,
                                               input logic lower);
      logic [12:0] sum;
      sum = {1'b0, idle} + {3'b0, offset};
      if (lower) begin
         return ({2'b0, offset} >= idle) ? 12'd0 : idle - {2'b0, offset};
      end
      return sum[12] ? 12'hFFF : sum[11:0];
   endfunction

endpackage

/* src/trapezoid_servo_motion_controller.sv */
// Servo motion controller with a trapezoidal speed profile. One request at a time:
// an encoder step, a homing request, a rejected move or a tick that is idle, creeps
// or ends the move goes through the decode and done states only; an accepted move
// and a driving tick use the multiply states and the shared divider (peak speed once
// per trapezoid move, speed on each ramp tick of one, pulse offset on every driving
// tick). The response waits in an output register until taken; req_stall is high
// from acceptance until the response is loaded into that register.
// Depends on tsmc_pkg and tsmc_div.
module trapezoid_servo_motion_controller #(
   parameter int unsigned MAX_PROFILE_TICKS = tsmc_pkg::MAX_PROFILE_TICKS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_command,
   input  logic               req_switch_closed,
   input  logic               req_step_up,
   input  logic [9:0]         req_target_position,
   input  logic [11:0]        req_duration_ticks,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [11:0]        rsp_pulse_us,
   output logic               rsp_accepted,
   output logic               rsp_moving,
   output logic signed [10:0] rsp_position_now,
   output logic [2:0]         rsp_status,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [13:0]        csr_wdata
);
   localparam int unsigned W = tsmc_pkg::DIV_W;

   tsmc_pkg::state_type state_ff, state_in;
   tsmc_pkg::cmd_type   cmd_ff, cmd_in;
   tsmc_pkg::kind_type  kind_ff, kind_in;
   tsmc_pkg::dop_type   dop_ff, dop_in;
   tsmc_pkg::div_req_type div_req;
   tsmc_pkg::div_rsp_type div_rsp;

   logic [13:0] period_ff, period_in;
   logic [9:0]  max_pos_ff, max_pos_in;
   logic [7:0]  min_spd_ff, min_spd_in;
   logic [7:0]  max_spd_ff, max_spd_in;
   logic [9:0]  range_ff, range_in;
   logic [9:0]  dband_ff, dband_in;
   logic [11:0] idle_ff, idle_in;

   logic signed [10:0] pos_ff, pos_in;
   logic [9:0]  tgt_ff, tgt_in;
   logic        lower_ff, lower_in;
   logic        busy_ff, busy_in;
   logic [12:0] step_ff, step_in;
   logic [11:0] plen_ff, plen_in;
   logic [17:0] peak_ff, peak_in;
   logic [11:0] pulse_ff, pulse_in;

   logic        sw_ff, sw_in;
   logic        up_ff, up_in;
   logic [9:0]  rtgt_ff, rtgt_in;
   logic [11:0] dur_ff, dur_in;
   logic [10:0] dist_ff, dist_in;
   logic [25:0] dp_ff, dp_in;
   logic [20:0] prod_a_ff, prod_a_in;
   logic [33:0] prod_b_ff, prod_b_in;
   logic [33:0] prod_c_ff, prod_c_in;
   logic [W-1:0] num_ff, num_in;
   logic [W-1:0] den_ff, den_in;
   logic [10:0] spd_ff, spd_in;
   logic [14:0] fac_ff, fac_in;
   logic        acc_ff, acc_in;
   logic [2:0]  stat_ff, stat_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [11:0] rsp_pulse_ff, rsp_pulse_in;
   logic        rsp_acc_ff, rsp_acc_in;
   logic        rsp_moving_ff, rsp_moving_in;
   logic signed [10:0] rsp_pos_ff, rsp_pos_in;
   logic [2:0]  rsp_stat_ff, rsp_stat_in;

   logic [13:0] period_eff;
   logic [7:0]  ms_eff;
   logic signed [11:0] diff, diff_neg;
   logic signed [10:0] tgt_s;
   logic        move_ok, reached;
   logic [12:0] k_idx, d13, d_minus_k;
   logic [14:0] k3, d15;
   logic [18:0] peak_rnd;
   logic [7:0]  spd_clamp;
   logic        req_take, rsp_free;

   assign period_eff = (period_ff == '0) ? 14'd1 : period_ff;
   assign ms_eff = (max_spd_ff == '0) ? 8'd1 : max_spd_ff;
   assign req_stall = reset || (state_ff != tsmc_pkg::ST_IDLE);
   assign req_take = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   tsmc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      diff = $signed({2'b0, rtgt_ff}) - $signed({pos_ff[10], pos_ff});
      diff_neg = -diff;
      tgt_s = $signed({1'b0, tgt_ff});
      move_ok = !busy_ff && (rtgt_ff <= max_pos_ff) && (diff != '0)
                && (dur_ff != '0) && ({20'd0, dur_ff} <= MAX_PROFILE_TICKS);
      reached = lower_ff ? (pos_ff <= tgt_s) : (pos_ff >= tgt_s);
      k_idx = step_ff + 13'd1;
      d13 = {1'b0, plen_ff};
      d_minus_k = d13 - k_idx;
      k3 = {2'b0, k_idx} * 15'd3;
      d15 = {3'b0, plen_ff};
      peak_rnd = {1'b0, peak_ff} + 19'd128;
      spd_clamp = (spd_ff > {3'b0, ms_eff}) ? ms_eff : spd_ff[7:0];

      div_req.start = (state_ff == tsmc_pkg::ST_DIV_GO);
      div_req.dividend = num_ff;
      div_req.divisor = den_ff;

      state_in = state_ff;
      cmd_in = cmd_ff;
      kind_in = kind_ff;
      dop_in = dop_ff;
      period_in = period_ff;
      max_pos_in = max_pos_ff;
      min_spd_in = min_spd_ff;
      max_spd_in = max_spd_ff;
      range_in = range_ff;
      dband_in = dband_ff;
      idle_in = idle_ff;
      pos_in = pos_ff;
      tgt_in = tgt_ff;
      lower_in = lower_ff;
      busy_in = busy_ff;
      step_in = step_ff;
      plen_in = plen_ff;
      peak_in = peak_ff;
      pulse_in = pulse_ff;
      sw_in = sw_ff;
      up_in = up_ff;
      rtgt_in = rtgt_ff;
      dur_in = dur_ff;
      dist_in = dist_ff;
      dp_in = dp_ff;
      prod_a_in = prod_a_ff;
      prod_b_in = prod_b_ff;
      prod_c_in = prod_c_ff;
      num_in = num_ff;
      den_in = den_ff;
      spd_in = spd_ff;
      fac_in = fac_ff;
      acc_in = acc_ff;
      stat_in = stat_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_pulse_in = rsp_pulse_ff;
      rsp_acc_in = rsp_acc_ff;
      rsp_moving_in = rsp_moving_ff;
      rsp_pos_in = rsp_pos_ff;
      rsp_stat_in = rsp_stat_ff;

      if (csr_we) begin
         unique case (csr_index)
            tsmc_pkg::CSR_PERIOD:    period_in = csr_wdata;
            tsmc_pkg::CSR_MAX_POS:   max_pos_in = csr_wdata[9:0];
            tsmc_pkg::CSR_MIN_SPEED: min_spd_in = csr_wdata[7:0];
            tsmc_pkg::CSR_MAX_SPEED: max_spd_in = csr_wdata[7:0];
            tsmc_pkg::CSR_RANGE:     range_in = csr_wdata[9:0];
            tsmc_pkg::CSR_DEAD_BAND: dband_in = csr_wdata[9:0];
            tsmc_pkg::CSR_IDLE:      idle_in = csr_wdata[11:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         tsmc_pkg::ST_IDLE: begin
            if (req_take) begin
               cmd_in = tsmc_pkg::cmd_type'(req_command);
               sw_in = req_switch_closed;
               up_in = req_step_up;
               rtgt_in = req_target_position;
               dur_in = req_duration_ticks;
               acc_in = 1'b0;
               stat_in = tsmc_pkg::STAT_NONE;
               state_in = tsmc_pkg::ST_DECODE;
            end
         end
         tsmc_pkg::ST_DECODE: begin
            state_in = tsmc_pkg::ST_DONE;
            unique case (cmd_ff)
               tsmc_pkg::CMD_TICK: begin
                  if (busy_ff) begin
                     priority if (lower_ff && sw_ff) begin
                        busy_in = 1'b0;
                        pos_in = '0;
                        tgt_in = '0;
                        pulse_in = idle_ff;
                        stat_in = tsmc_pkg::STAT_HOME;
                     end else if (reached) begin
                        busy_in = 1'b0;
                        pulse_in = idle_ff;
                        stat_in = tsmc_pkg::STAT_REACH;
                     end else if (step_ff < d13) begin
                        if (kind_ff != tsmc_pkg::KIND_TRAP) begin
                           spd_in = (k_idx >= d13) ? 11'd0 : {1'b0, peak_ff[17:8]};
                           state_in = tsmc_pkg::ST_OFF_MUL;
                        end else if (k3 < d15) begin
                           fac_in = k3;
                           state_in = tsmc_pkg::ST_TK_MUL;
                        end else if (k3 < {d15[13:0], 1'b0}) begin
                           // cruise: rounded peak
                           spd_in = peak_rnd[18:8];
                           state_in = tsmc_pkg::ST_OFF_MUL;
                        end else begin
                           fac_in = {2'b0, d_minus_k} * 15'd3;
                           state_in = tsmc_pkg::ST_TK_MUL;
                        end
                     end else begin
                        pulse_in = tsmc_pkg::drive_pulse(idle_ff, dband_ff, lower_ff);
                        stat_in = tsmc_pkg::STAT_CREEP;
                     end
                  end
               end
               tsmc_pkg::CMD_STEP: begin
                  if (up_ff) begin
                     if (pos_ff != 11'sd1023) pos_in = pos_ff + 11'sd1;
                  end else begin
                     if (pos_ff != -11'sd1024) pos_in = pos_ff - 11'sd1;
                  end
               end
               tsmc_pkg::CMD_MOVE: begin
                  dist_in = diff[11] ? diff_neg[10:0] : diff[10:0];
                  dp_in = {14'd0, dur_ff} * {12'd0, period_eff};
                  if (move_ok) begin
                     tgt_in = rtgt_ff;
                     lower_in = diff[11];
                     plen_in = dur_ff;
                     step_in = '0;
                     busy_in = 1'b1;
                     acc_in = 1'b1;
                     state_in = tsmc_pkg::ST_MV_MUL;
                  end
               end
               tsmc_pkg::CMD_HOME: begin
                  if (!busy_ff) begin
                     tgt_in = '0;
                     lower_in = 1'b1;
                     step_in = '0;
                     plen_in = '0;
                     busy_in = 1'b1;
                     acc_in = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         tsmc_pkg::ST_MV_MUL: begin
            prod_a_in = {10'd0, dist_ff} * 21'd1000;
            prod_b_in = {26'd0, min_spd_ff} * {8'd0, dp_ff};
            prod_c_in = {26'd0, ms_eff} * {8'd0, dp_ff};
            // 1.5 times average speed in q8
            num_in = {23'd0, dist_ff} * 34'd384000;
            state_in = tsmc_pkg::ST_MV_CMP;
         end
         tsmc_pkg::ST_MV_CMP: begin
            priority if ({13'd0, prod_a_ff} <= prod_b_ff) begin
               kind_in = tsmc_pkg::KIND_MIN;
               peak_in = {2'b0, min_spd_ff, 8'd0};
               state_in = tsmc_pkg::ST_DONE;
            end else if ({13'd0, prod_a_ff} >= prod_c_ff) begin
               kind_in = tsmc_pkg::KIND_MAX;
               peak_in = {2'b0, ms_eff, 8'd0};
               state_in = tsmc_pkg::ST_DONE;
            end else begin
               kind_in = tsmc_pkg::KIND_TRAP;
               den_in = {8'd0, dp_ff};
               dop_in = tsmc_pkg::DOP_PEAK;
               state_in = tsmc_pkg::ST_DIV_GO;
            end
         end
         tsmc_pkg::ST_TK_MUL: begin
            num_in = {16'd0, peak_ff} * {19'd0, fac_ff};
            state_in = tsmc_pkg::ST_TK_ADD;
         end
         tsmc_pkg::ST_TK_ADD: begin
            // half-up rounding of product / (256 d)
            num_in = num_ff + {15'd0, plen_ff, 7'd0};
            den_in = {14'd0, plen_ff, 8'd0};
            dop_in = tsmc_pkg::DOP_SPEED;
            state_in = tsmc_pkg::ST_DIV_GO;
         end
         tsmc_pkg::ST_OFF_MUL: begin
            num_in = {26'd0, spd_clamp} * {24'd0, range_ff};
            den_in = {26'd0, ms_eff};
            dop_in = tsmc_pkg::DOP_OFFSET;
            state_in = tsmc_pkg::ST_DIV_GO;
         end
         tsmc_pkg::ST_DIV_GO: begin
            state_in = tsmc_pkg::ST_DIV_WAIT;
         end
         tsmc_pkg::ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               unique case (dop_ff)
                  tsmc_pkg::DOP_PEAK: begin
                     peak_in = div_rsp.quotient[17:0];
                     state_in = tsmc_pkg::ST_DONE;
                  end
                  tsmc_pkg::DOP_SPEED: begin
                     spd_in = div_rsp.quotient[10:0];
                     state_in = tsmc_pkg::ST_OFF_MUL;
                  end
                  tsmc_pkg::DOP_OFFSET: begin
                     pulse_in = tsmc_pkg::drive_pulse(idle_ff, div_rsp.quotient[9:0],
                                                      lower_ff);
                     step_in = step_ff + 13'd1;
                     stat_in = tsmc_pkg::STAT_DRIVE;
                     state_in = tsmc_pkg::ST_DONE;
                  end
                  default: state_in = tsmc_pkg::ST_DONE;
               endcase
            end
         end
         tsmc_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_pulse_in = pulse_ff;
               rsp_acc_in = acc_ff;
               rsp_moving_in = busy_ff;
               rsp_pos_in = pos_ff;
               rsp_stat_in = stat_ff;
               state_in = tsmc_pkg::ST_IDLE;
            end
         end
         default: state_in = tsmc_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tsmc_pkg::ST_IDLE;
         period_ff <= tsmc_pkg::PERIOD_RST;
         max_pos_ff <= tsmc_pkg::MAX_POS_RST;
         min_spd_ff <= tsmc_pkg::MIN_SPEED_RST;
         max_spd_ff <= tsmc_pkg::MAX_SPEED_RST;
         range_ff <= tsmc_pkg::RANGE_RST;
         dband_ff <= tsmc_pkg::DEAD_BAND_RST;
         idle_ff <= tsmc_pkg::IDLE_PULSE_RST;
         pos_ff <= tsmc_pkg::POSITION_RST;
         tgt_ff <= '0;
         lower_ff <= 1'b0;
         busy_ff <= 1'b0;
         step_ff <= '0;
         plen_ff <= '0;
         peak_ff <= '0;
         kind_ff <= tsmc_pkg::KIND_TRAP;
         pulse_ff <= tsmc_pkg::IDLE_PULSE_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         period_ff <= period_in;
         max_pos_ff <= max_pos_in;
         min_spd_ff <= min_spd_in;
         max_spd_ff <= max_spd_in;
         range_ff <= range_in;
         dband_ff <= dband_in;
         idle_ff <= idle_in;
         pos_ff <= pos_in;
         tgt_ff <= tgt_in;
         lower_ff <= lower_in;
         busy_ff <= busy_in;
         step_ff <= step_in;
         plen_ff <= plen_in;
         peak_ff <= peak_in;
         kind_ff <= kind_in;
         pulse_ff <= pulse_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff <= cmd_in;
      dop_ff <= dop_in;
      sw_ff <= sw_in;
      up_ff <= up_in;
      rtgt_ff <= rtgt_in;
      dur_ff <= dur_in;
      dist_ff <= dist_in;
      dp_ff <= dp_in;
      prod_a_ff <= prod_a_in;
      prod_b_ff <= prod_b_in;
      prod_c_ff <= prod_c_in;
      num_ff <= num_in;
      den_ff <= den_in;
      spd_ff <= spd_in;
      fac_ff <= fac_in;
      acc_ff <= acc_in;
      stat_ff <= stat_in;
      rsp_pulse_ff <= rsp_pulse_in;
      rsp_acc_ff <= rsp_acc_in;
      rsp_moving_ff <= rsp_moving_in;
      rsp_pos_ff <= rsp_pos_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pulse_us = rsp_pulse_ff;
   assign rsp_accepted = rsp_acc_ff;
   assign rsp_moving = rsp_moving_ff;
   assign rsp_position_now = rsp_pos_ff;
   assign rsp_status = rsp_stat_ff;

endmodule

/* src/tsmc_div.sv */
// shared restoring divider, one quotient bit per cycle
// depends on tsmc_pkg
module tsmc_div (
   input  logic                  clock,
   input  logic                  reset,
   input  tsmc_pkg::div_req_type div_req,
   output tsmc_pkg::div_rsp_type div_rsp
);
   localparam int unsigned W = tsmc_pkg::DIV_W;
   localparam int unsigned CNT_W = $clog2(W);

   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [W:0]       rem_ff, rem_in;
   logic [W-1:0]     quo_ff, quo_in;
   logic [W-1:0]     den_ff, den_in;
   logic [W:0]       trial;
   logic             fits;

   always_comb begin
      trial = {rem_ff[W-1:0], quo_ff[W-1]};
      fits = trial >= {1'b0, den_ff};
      run_in = run_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      den_in = den_ff;
      if (div_req.start) begin
         run_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         quo_in = div_req.dividend;
         den_in = div_req.divisor;
      end else if (run_ff) begin
         rem_in = fits ? trial - {1'b0, den_ff} : trial;
         quo_in = {quo_ff[W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(W - 1)) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

/* src/tsmc_checker.sv */
// port-level checks of the servo motion controller, bound to the top level
// depends on tsmc_pkg and the assertion macro header
`include "trapezoid_servo_motion_controller_macros.svh"

module tsmc_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic [1:0]         req_command,
   input logic               req_switch_closed,
   input logic               req_step_up,
   input logic [9:0]         req_target_position,
   input logic [11:0]        req_duration_ticks,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [11:0]        rsp_pulse_us,
   input logic               rsp_accepted,
   input logic               rsp_moving,
   input logic signed [10:0] rsp_position_now,
   input logic [2:0]         rsp_status,
   input logic               csr_we,
   input logic [2:0]         csr_index,
   input logic [13:0]        csr_wdata
);

   // a stalled response holds
   `TSMC_ASSERT(a_rsp_hold, !reset && rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pulse_us) && $stable(rsp_position_now) && $stable(rsp_status), "response changed while stalled")

   // one request at a time: stall rises after an accepted request
   `TSMC_ASSERT(a_one_at_a_time, !reset && req_valid && !req_stall |=> req_stall, "second request taken while busy")

   // accepted responses carry no status (only ticks report a status, only move or homing requests are accepted)
   `TSMC_ASSERT(a_status_excl, rsp_valid && rsp_accepted |-> rsp_status == tsmc_pkg::STAT_NONE, "accepted request with tick status")

   // homing done leaves the block stopped at zero
   `TSMC_ASSERT(a_home_zero, rsp_valid && rsp_status == tsmc_pkg::STAT_HOME |-> rsp_position_now == 11'sd0 && !rsp_moving, "homing done not at zero")

   // no response right after reset
   `TSMC_ASSERT_ALWAYS(a_reset_empty, $past(reset) |-> !rsp_valid, "response valid after reset")

endmodule

bind trapezoid_servo_motion_controller tsmc_checker u_tsmc_checker (.*);

/* dv/trapezoid_servo_motion_controller_test.sv */
// self-checking testbench for the trapezoidal servo motion controller
// drives requests and register writes, predicts every response; needs tsmc_pkg and the rtl
module trapezoid_servo_motion_controller_test;

   localparam logic [2:0] CSR_UNUSED = 3'd7;
   localparam int unsigned CYCLE_LIMIT = 4_000_000;
   localparam int RANDOM_ITEMS = 500;

   typedef struct {
      logic [11:0]        pulse;
      logic               accepted;
      logic               moving;
      logic signed [10:0] position;
      logic [2:0]         status;
   } servo_resp_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_command;
   logic               req_switch_closed;
   logic               req_step_up;
   logic [9:0]         req_target_position;
   logic [11:0]        req_duration_ticks;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [11:0]        rsp_pulse_us;
   logic               rsp_accepted;
   logic               rsp_moving;
   logic signed [10:0] rsp_position_now;
   logic [2:0]         rsp_status;
   logic               csr_we;
   logic [2:0]         csr_index;
   logic [13:0]        csr_wdata;

   // register copies
   int unsigned period_ms, max_pos, min_spd, max_spd, pulse_rng, dead_bnd, idle_us;
   // controller copies
   int          cur_pos;
   int unsigned cur_target, cur_index, cur_length, cur_peak;
   bit          lower_dir, busy;
   tsmc_pkg::kind_type cur_kind;
   logic [11:0] pulse_now;

   servo_resp_type expected_q[$];
   int unsigned cycle_count;
   int          mismatches;
   int          item_count;
   bit          quiet;
   int          stall_left;

   trapezoid_servo_motion_controller u_dut (.*);

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // response side stalls, mostly short
   always @(negedge clock) begin
      if (reset || quiet) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         int r;
         r = $urandom_range(0, 99);
         rsp_stall <= (r >= 60);
         if (r >= 95) stall_left <= $urandom_range(8, 30);
         else if (r >= 60) stall_left <= $urandom_range(0, 2);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         servo_resp_type e;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("response with no request pending");
         end else begin
            e = expected_q.pop_front();
            if (e.pulse !== rsp_pulse_us || e.accepted !== rsp_accepted ||
                e.moving !== rsp_moving || e.position !== rsp_position_now ||
                e.status !== rsp_status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: exp pulse %0d acc %0d mov %0d pos %0d st %0d, ",
                            "got %0d %0d %0d %0d %0d"},
                     e.pulse, e.accepted, e.moving, e.position, e.status, rsp_pulse_us,
                     rsp_accepted, rsp_moving, rsp_position_now, rsp_status);
            end
         end
      end
   end

   function automatic longint unsigned profile_speed();
      longint unsigned k, d, p;
      k = cur_index + 1;
      d = cur_length;
      p = cur_peak;
      if (d == 0) return 0;
      if (cur_kind != tsmc_pkg::KIND_TRAP) return (k >= d) ? 0 : (p >> 8);
      if (3 * k < d) return (p * 3 * k + 128 * d) / (256 * d);
      if (3 * k < 2 * d) return (p + 128) >> 8;
      if (k > d) k = d;
      return (p * 3 * (d - k) + 128 * d) / (256 * d);
   endfunction

   function automatic logic [11:0] offset_pulse(input int unsigned offset);
      if (lower_dir) return (offset >= idle_us) ? 12'd0 : 12'(idle_us - offset);
      return (idle_us + offset > 4095) ? 12'd4095 : 12'(idle_us + offset);
   endfunction

   function automatic void predict_response(input tsmc_pkg::cmd_type cmd, input bit sw,
                                            input bit up, input int unsigned tgt,
                                            input int unsigned dur);
      servo_resp_type r;
      longint unsigned ms, s, distance, dp;
      bit acc;
      logic [2:0] st;
      acc = 1'b0;
      st = tsmc_pkg::STAT_NONE;
      ms = (max_spd != 0) ? max_spd : 1;
      case (cmd)
         tsmc_pkg::CMD_TICK: begin
            if (busy) begin
               if (lower_dir && sw) begin
                  busy = 0; cur_pos = 0; cur_target = 0; pulse_now = 12'(idle_us);
                  st = tsmc_pkg::STAT_HOME;
               end else if ((lower_dir && cur_pos <= int'(cur_target)) ||
                            (!lower_dir && cur_pos >= int'(cur_target))) begin
                  busy = 0; pulse_now = 12'(idle_us); st = tsmc_pkg::STAT_REACH;
               end else if (cur_index < cur_length) begin
                  s = profile_speed();
                  if (s > ms) s = ms;
                  pulse_now = offset_pulse(int'(s * pulse_rng / ms));
                  cur_index = (cur_index + 1) & 13'h1FFF;
                  st = tsmc_pkg::STAT_DRIVE;
               end else begin
                  pulse_now = offset_pulse(dead_bnd);
                  st = tsmc_pkg::STAT_CREEP;
               end
            end
         end
         tsmc_pkg::CMD_STEP: begin
            if (up && cur_pos < 1023) cur_pos++;
            if (!up && cur_pos > -1024) cur_pos--;
         end
         tsmc_pkg::CMD_MOVE: begin
            if (!busy && tgt <= max_pos && int'(tgt) != cur_pos && dur != 0 && dur <= 4095)
            begin
               distance = (int'(tgt) > cur_pos) ? int'(tgt) - cur_pos : cur_pos - int'(tgt);
               dp = longint'(dur) * ((period_ms != 0) ? period_ms : 1);
               cur_target = tgt;
               lower_dir = (int'(tgt) < cur_pos);
               if (distance * 1000 <= min_spd * dp) begin
                  cur_kind = tsmc_pkg::KIND_MIN; cur_peak = min_spd << 8;
               end else if (distance * 1000 >= ms * dp) begin
                  cur_kind = tsmc_pkg::KIND_MAX; cur_peak = 32'(ms << 8);
               end else begin
                  cur_kind = tsmc_pkg::KIND_TRAP;
                  cur_peak = 32'((distance * 384000 / dp) & 18'h3FFFF);
               end
               cur_length = dur; cur_index = 0; busy = 1; acc = 1;
            end
         end
         default: begin
            if (!busy) begin
               cur_target = 0; lower_dir = 1; cur_index = 0; cur_length = 0;
               busy = 1; acc = 1;
            end
         end
      endcase
      r.pulse = pulse_now;
      r.accepted = acc;
      r.moving = busy;
      r.position = 11'(cur_pos);
      r.status = st;
      expected_q.push_back(r);
   endfunction

   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   task automatic send_request(input tsmc_pkg::cmd_type cmd, input bit sw, input bit up,
                               input logic [9:0] tgt, input logic [11:0] dur);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_command <= cmd;
      req_switch_closed <= sw;
      req_step_up <= up;
      req_target_position <= tgt;
      req_duration_ticks <= dur;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      predict_response(cmd, sw, up, tgt, dur);
      item_count++;
   endtask

   task automatic tick(input bit sw);
      send_request(tsmc_pkg::CMD_TICK, sw, 1'($urandom_range(0, 1)), 10'($urandom),
                   12'($urandom));
   endtask

   task automatic step(input bit up);
      send_request(tsmc_pkg::CMD_STEP, 1'($urandom_range(0, 1)), up, 10'($urandom),
                   12'($urandom));
   endtask

   task automatic move(input int unsigned tgt, input int unsigned dur);
      send_request(tsmc_pkg::CMD_MOVE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   10'(tgt), 12'(dur));
   endtask

   task automatic home();
      send_request(tsmc_pkg::CMD_HOME, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   10'($urandom), 12'($urandom));
   endtask

   task automatic wait_all_responses();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input int unsigned value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= 14'(value);
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         tsmc_pkg::CSR_PERIOD:    period_ms = value & 14'h3FFF;
         tsmc_pkg::CSR_MAX_POS:   max_pos = value & 10'h3FF;
         tsmc_pkg::CSR_MIN_SPEED: min_spd = value & 8'hFF;
         tsmc_pkg::CSR_MAX_SPEED: max_spd = value & 8'hFF;
         tsmc_pkg::CSR_RANGE:     pulse_rng = value & 10'h3FF;
         tsmc_pkg::CSR_DEAD_BAND: dead_bnd = value & 10'h3FF;
         tsmc_pkg::CSR_IDLE:      idle_us = value & 12'hFFF;
         default: ;
      endcase
   endtask

   task automatic write_all(input int unsigned p, input int unsigned mp, input int unsigned mn,
                            input int unsigned mx, input int unsigned rg, input int unsigned db,
                            input int unsigned id);
      wait_all_responses();
      write_reg(tsmc_pkg::CSR_PERIOD, p);
      write_reg(tsmc_pkg::CSR_MAX_POS, mp);
      write_reg(tsmc_pkg::CSR_MIN_SPEED, mn);
      write_reg(tsmc_pkg::CSR_MAX_SPEED, mx);
      write_reg(tsmc_pkg::CSR_RANGE, rg);
      write_reg(tsmc_pkg::CSR_DEAD_BAND, db);
      write_reg(tsmc_pkg::CSR_IDLE, id);
   endtask

   // steps up toward the target, or closes the switch when moving down (homing included), until the move ends
   task automatic finish_move();
      while (busy) begin
         if (lower_dir) tick(1'b1);
         else begin
            if (cur_pos < int'(cur_target)) step(1'b1);
            tick(1'b0);
         end
      end
   endtask

   task automatic run_sequence(input int n);
      int r;
      for (int i = 0; i < n && busy; i++) begin
         r = $urandom_range(0, 99);
         if (r < 55) tick(lower_dir && ($urandom_range(0, 15) == 0));
         else if (r < 88) step(!lower_dir);
         else if (r < 94) step(lower_dir);
         else if (r < 97) move($urandom_range(0, 1023), $urandom);
         else home();
      end
      finish_move();
   endtask

   function automatic int unsigned near_target();
      int t;
      if ($urandom_range(0, 9) < 3) return $urandom_range(0, max_pos + 4);
      t = cur_pos + $signed($urandom_range(0, 40)) - 20;
      if (t < 0) t = 0;
      if (t > 1023) t = 1023;
      return t;
   endfunction

   function automatic int unsigned pick_duration();
      int r;
      r = $urandom_range(0, 99);
      if (r < 3) return $urandom_range(0, 4095);
      if (r < 6) return 0;
      return $urandom_range(1, 24);
   endfunction

   task automatic random_items(input int n);
      int stop_at;
      stop_at = item_count + n;
      while (item_count < stop_at) begin
         case ($urandom_range(0, 9))
            0, 1: send_request(tsmc_pkg::cmd_type'($urandom_range(0, 3)),
                               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                               10'($urandom), 12'($urandom));
            2: begin
               home();
               run_sequence($urandom_range(0, 12));
            end
            default: begin
               move(near_target(), pick_duration());
               run_sequence($urandom_range(3, 40));
            end
         endcase
         finish_move();
      end
   endtask

   task automatic test_directed();
      tick(1'b0);
      step(1'b1);
      step(1'b0);
      move(10, 0);
      move(51, 5);
      move(50, 5);
      home();
      home();
      move(20, 5);
      tick(1'b0);
      tick(1'b1);
      move(1023, 4095);
      move(0, 4095);
      wait_all_responses();
      write_reg(tsmc_pkg::CSR_MAX_POS, 1023);
      move(600, 30);
      tick(1'b0);
      step(1'b1);
      tick(1'b0);
      finish_move();
      move(610, 1);
      tick(1'b0);
      tick(1'b0);
      finish_move();
   endtask

   task automatic test_profiles();
      // trapezoid, flat minimum and flat maximum shapes at default speeds
      wait_all_responses();
      write_reg(CSR_UNUSED, 14'h3FFF);
      write_all(100, 50, 1, 40, 750, 90, 1500);
      home();
      tick(1'b1);
      move(10, 30);
      repeat (32) tick(1'b0);
      finish_move();
      move(11, 20);
      repeat (4) tick(1'b0);
      finish_move();
      move(40, 1);
      repeat (3) tick(1'b0);
      finish_move();
   endtask

   task automatic test_settings();
      write_all(1, 1023, 0, 255, 1023, 1023, 3071);
      random_items(60);
      write_all(10000, 1023, 255, 1, 1023, 0, 1024);
      random_items(60);
      write_all(0, 0, 0, 0, 0, 1023, 1024);
      random_items(40);
      write_all(3, 200, 2, 255, 1023, 1023, 1024);
      random_items(60);
      write_all(7, 300, 5, 200, 1023, 1023, 3071);
      random_items(60);
   endtask

   task automatic test_saturation();
      quiet = 1'b1;
      repeat (1000) step(1'b1);
      repeat (2060) step(1'b0);
      quiet = 1'b0;
      home();
      tick(1'b1);
   endtask

   task automatic test_random();
      write_all(100, 100, 1, 40, 750, 90, 1500);
      random_items(RANDOM_ITEMS / 2);
      quiet = 1'b1;
      random_items(40);
      quiet = 1'b0;
      write_all($urandom_range(1, 40), $urandom_range(20, 1023), $urandom_range(0, 30),
                $urandom_range(30, 255), $urandom_range(0, 1023), $urandom_range(0, 1023),
                $urandom_range(1024, 3071));
      random_items(RANDOM_ITEMS / 2);
   endtask

   task automatic test_pause();
      move(near_target(), $urandom_range(1, 10));
      wait_all_responses();
      run_sequence(10);
      wait_all_responses();
      tick(1'b0);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = tsmc_pkg::CMD_TICK;
      req_switch_closed = 1'b0;
      req_step_up = 1'b0;
      req_target_position = '0;
      req_duration_ticks = '0;
      rsp_stall = 1'b0;
      csr_we = 1'b0;
      csr_index = tsmc_pkg::CSR_PERIOD;
      csr_wdata = '0;
      cycle_count = 0;
      mismatches = 0;
      item_count = 0;
      quiet = 1'b0;
      stall_left = 0;
      period_ms = tsmc_pkg::PERIOD_RST; max_pos = tsmc_pkg::MAX_POS_RST;
      min_spd = tsmc_pkg::MIN_SPEED_RST; max_spd = tsmc_pkg::MAX_SPEED_RST;
      pulse_rng = tsmc_pkg::RANGE_RST; dead_bnd = tsmc_pkg::DEAD_BAND_RST;
      idle_us = tsmc_pkg::IDLE_PULSE_RST;
      cur_pos = tsmc_pkg::POSITION_RST; cur_target = 0; lower_dir = 0; busy = 0;
      cur_index = 0; cur_length = 0; cur_peak = 0; cur_kind = tsmc_pkg::KIND_TRAP;
      pulse_now = tsmc_pkg::IDLE_PULSE_RST;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_profiles();
      test_pause();
      test_settings();
      test_saturation();
      test_random();

      wait_all_responses();
      repeat (100) @(posedge clock);
      if (mismatches == 0 && expected_q.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+src
src/tsmc_pkg.sv
src/tsmc_div.sv
src/trapezoid_servo_motion_controller.sv
src/tsmc_checker.sv
dv/trapezoid_servo_motion_controller_test.sv
